>>> sv/fpalu_pkg.sv
// Package for the Q24.8 fixed-point ALU: opcodes, payload structs, widths.
// No dependencies.
package fpalu_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DATA_W = 32;
   localparam int DIV_N_W = DATA_W + FRAC_BITS + 1;  // numerator 2*|a|<<F
   localparam int DIV_D_W = DATA_W + 1;              // divisor 2*|b|

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_DIV  = 4'd3,
      OP_MIN  = 4'd4,
      OP_MAX  = 4'd5,
      OP_TOI  = 4'd6,
      OP_FROMI = 4'd7,
      OP_INCR = 4'd8,
      OP_DECR = 4'd9
   } op_type;

   typedef struct packed {
      logic [3:0]        op;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic              a_greater;
      logic              a_less;
      logic              a_equal;
      logic              overflowed;
      logic              divide_by_zero;
   } rsp_type;

   // Per-item control that rides along the divider pipeline.
   typedef struct packed {
      logic [3:0]  op;
      logic        neg;
      logic        dz;
      logic        a_greater;
      logic        a_less;
      logic        a_equal;
      logic [32:0] simple;     // 33-bit signed result of simple ops
      logic        simple_ovf;
      logic [63:0] prod;       // |a|*|b|
   } ctl_type;

   // Saturate sign/magnitude to 32 bits.
   function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
      logic [32:0] r;
      if (!neg) begin
         if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
         else r = {1'b0, mag[31:0]};
      end else begin
         if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
         else r = {1'b0, 32'(-mag[31:0])};
      end
      return r;
   endfunction

endpackage

>>> sv/fpalu_front.sv
// Front stage of the Q24.8 ALU: compares, simple ops, magnitudes, multiply.
// Depends on fpalu_pkg.
module fpalu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  fpalu_pkg::req_type  in_word,
   output logic                out_valid,
   output fpalu_pkg::ctl_type  out_ctl,
   output logic [31:0]         out_ma,
   output logic [31:0]         out_mb
);
   import fpalu_pkg::*;

   logic [32:0] sa, sb, ma, mb;
   logic [32:0] sum;
   ctl_type ctl;
   logic valid_ff;
   ctl_type ctl_ff;
   logic [31:0] ma_ff, mb_ff;

   // Build per-item control from the operands.
   always_comb begin
      sa = {in_word.operand_a[31], in_word.operand_a};
      sb = {in_word.operand_b[31], in_word.operand_b};
      ma = sa[32] ? -sa : sa;
      mb = sb[32] ? -sb : sb;
      ctl = '0;
      ctl.op = in_word.op;
      ctl.neg = sa[32] ^ sb[32];
      ctl.dz = (mb == '0);
      ctl.a_greater = in_word.operand_a > in_word.operand_b;
      ctl.a_less = in_word.operand_a < in_word.operand_b;
      ctl.a_equal = in_word.operand_a == in_word.operand_b;
      sum = '0;
      case (in_word.op)
         OP_ADD: sum = sa + sb;
         OP_SUB: sum = sa - sb;
         OP_INCR: sum = sa + 33'd1;
         OP_DECR: sum = sa - 33'd1;
         OP_MIN: sum = ctl.a_less ? sa : sb;
         OP_MAX: sum = ctl.a_greater ? sa : sb;
         OP_TOI: sum = {sa[32], 32'(in_word.operand_a >>> FRAC_BITS)};
         OP_FROMI: begin
            // Shift up when the integer fits, else clamp to the range limit.
            if ((sa[32:DATA_W-FRAC_BITS-1] == '0) || (sa[32:DATA_W-FRAC_BITS-1] == '1)) begin
               sum = {sa[32], sa[DATA_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            end else begin
               sum = sa[32] ? {1'b1, 32'h8000_0000} : {1'b0, 32'h7FFF_FFFF};
               ctl.simple_ovf = 1'b1;
            end
         end
         default: sum = '0;
      endcase
      // Saturate the 33-bit sum.
      if (sum[32] != sum[31]) begin
         ctl.simple_ovf = 1'b1;
         ctl.simple = sum[32] ? {1'b1, 32'h8000_0000} : {1'b0, 32'h7FFF_FFFF};
      end else begin
         ctl.simple = sum;
      end
   end

   // Register stage one.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         ctl_ff <= ctl;
         ma_ff <= ma[31:0];
         mb_ff <= mb[31:0];
      end
   end

   // Product, registered in stage two.
   logic valid2_ff;
   ctl_type ctl_p;
   ctl_type ctl2_ff;
   logic [31:0] ma2_ff, mb2_ff;
   always_comb begin
      ctl_p = ctl_ff;
      ctl_p.prod = 64'(ma_ff) * 64'(mb_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (en) begin
         valid2_ff <= valid_ff;
      end
      if (en) begin
         ctl2_ff <= ctl_p;
         ma2_ff <= ma_ff;
         mb2_ff <= mb_ff;
      end
   end

   assign out_valid = valid2_ff;
   assign out_ctl = ctl2_ff;
   assign out_ma = ma2_ff;
   assign out_mb = mb2_ff;
endmodule

>>> sv/fpalu_div.sv
// Pipelined restoring divider, one quotient bit per stage, with the result
// mux and saturation at its end. Depends on fpalu_pkg.
module fpalu_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  fpalu_pkg::ctl_type  in_ctl,
   input  logic [31:0]         in_ma,
   input  logic [31:0]         in_mb,
   output logic                out_valid,
   output fpalu_pkg::rsp_type  out_word
);
   import fpalu_pkg::*;

   localparam int STAGES = DIV_N_W;

   // Per stage: partial remainder, numerator shift, divisor, quotient.
   logic              v_ff   [STAGES+1];
   ctl_type           c_ff   [STAGES+1];
   logic [DIV_D_W:0]  r_ff   [STAGES+1];
   logic [DIV_N_W-1:0] n_ff  [STAGES+1];
   logic [DIV_D_W-1:0] d_ff  [STAGES+1];

   // Load stage: numerator 2*|a|<<F plus |b|, divisor 2*|b|.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         c_ff[0] <= in_ctl;
         r_ff[0] <= '0;
         n_ff[0] <= ({1'b0, in_ma, {FRAC_BITS{1'b0}}} << 1) + DIV_N_W'(in_mb);
         d_ff[0] <= {in_mb, 1'b0};
      end
   end

   // Advance one quotient bit per stage.
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [DIV_D_W:0] trial;
      logic [DIV_D_W+1:0] diff;
      always_comb begin
         trial = {r_ff[s][DIV_D_W-1:0], n_ff[s][DIV_N_W-1]};
         diff = {1'b0, trial} - {2'b00, d_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (en) begin
            v_ff[s+1] <= v_ff[s];
         end
         if (en) begin
            c_ff[s+1] <= c_ff[s];
            d_ff[s+1] <= d_ff[s];
            r_ff[s+1] <= diff[DIV_D_W+1] ? trial : diff[DIV_D_W:0];
            n_ff[s+1] <= {n_ff[s][DIV_N_W-2:0], ~diff[DIV_D_W+1]};
         end
      end
   end

   // Select and saturate the final result.
   ctl_type c;
   logic [63:0] mq;
   logic [32:0] sm;
   rsp_type w;
   logic valid_ff;
   rsp_type word_ff;
   always_comb begin
      c = c_ff[STAGES];
      w = '0;
      w.a_greater = c.a_greater;
      w.a_less = c.a_less;
      w.a_equal = c.a_equal;
      mq = (c.prod + 64'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      sm = '0;
      case (c.op) inside
         OP_ADD, OP_SUB, OP_MIN, OP_MAX, OP_TOI, OP_FROMI, OP_INCR, OP_DECR: begin
            w.result = c.simple[31:0];
            w.overflowed = c.simple_ovf;
         end
         OP_MUL: begin
            sm = sat_mag(c.neg, mq);
            w.result = sm[31:0];
            w.overflowed = sm[32];
         end
         OP_DIV: begin
            if (c.dz) begin
               w.divide_by_zero = 1'b1;
            end else begin
               sm = sat_mag(c.neg, 64'(n_ff[STAGES]));
               w.result = sm[31:0];
               w.overflowed = sm[32];
            end
         end
         default: w.result = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= v_ff[STAGES];
      end
      if (en) begin
         word_ff <= w;
      end
   end

   assign out_valid = valid_ff;
   assign out_word = word_ff;
endmodule

>>> sv/fixed_point_q24_8_alu.sv
// Top level of the Q24.8 fixed-point ALU: front stages, divider pipeline,
// output skid register. Depends on fpalu_pkg, fpalu_front, fpalu_div.

// Q24.8 ALU with valid/ready channels. One word is accepted every cycle
// while the skid register is empty; each word's result passes two front
// stages, a 41-stage radix-2 divider pipeline with one bit per stage that
// every opcode travels through, and one load and one result stage. The whole
// pipeline advances together; when the output holds a result not taken, a
// skid register catches the one word in flight so no word is lost.
module fixed_point_q24_8_alu (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fpalu_pkg::req_type  req_word,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fpalu_pkg::rsp_type  rsp_word
);
   import fpalu_pkg::*;

   logic en;
   logic f_valid;
   ctl_type f_ctl;
   logic [31:0] f_ma, f_mb;
   logic p_valid;
   rsp_type p_word;
   logic skid_valid_ff, skid_valid_in;
   rsp_type skid_ff;

   // Advance the pipe whenever the skid register is empty.
   assign en = !skid_valid_ff;
   assign req_ready = en;

   fpalu_front u_front (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_valid), .in_word(req_word),
      .out_valid(f_valid), .out_ctl(f_ctl), .out_ma(f_ma), .out_mb(f_mb)
   );

   fpalu_div u_div (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(f_valid), .in_ctl(f_ctl), .in_ma(f_ma), .in_mb(f_mb),
      .out_valid(p_valid), .out_word(p_word)
   );

   // Hold a result in the skid register while the pipe stalls.
   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff && rsp_ready) skid_valid_in = 1'b0;
      else if (!skid_valid_ff && p_valid && !rsp_ready) skid_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
      if (!skid_valid_ff) begin
         skid_ff <= p_word;
      end
   end

   assign rsp_valid = skid_valid_ff || p_valid;
   assign rsp_word = skid_valid_ff ? skid_ff : p_word;

   // The skid register fills only on a stalled output.
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      !skid_valid_ff && skid_valid_in |-> p_valid && !rsp_ready)
      else $error("skid filled without a stall");
   // Input is refused only while the skid register holds a word.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> skid_valid_ff)
      else $error("ready low without held word");
   // A held word is shown until taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_ready |=> skid_valid_ff && $stable(skid_ff))
      else $error("held word lost");
endmodule

>>> dv/tb_top.sv
// Testbench for the Q24.8 fixed-point ALU: random and directed words, bursty
// sender, stalling receiver, scoreboard checks every result. Depends on fpalu_pkg.

module tb_top;
   import fpalu_pkg::*;

   // Expected results of accepted words, oldest first
   class alu_scoreboard;
      rsp_type pending_rsp[$];
      int err_count;

      function automatic logic [31:0] saturate(input logic neg, input logic [63:0] mag,
                                               inout logic ovf);
         if (!neg) begin
            if (mag > 64'h7FFF_FFFF) begin
               ovf = 1'b1;
               return 32'h7FFF_FFFF;
            end
            return mag[31:0];
         end
         if (mag > 64'h8000_0000) begin
            ovf = 1'b1;
            return 32'h8000_0000;
         end
         return 32'(-mag[31:0]);
      endfunction

      function automatic logic [31:0] saturate_sum(input longint v, inout logic ovf);
         logic [63:0] mag;
         mag = (v < 0) ? 64'(-v) : 64'(v);
         return saturate(v < 0, mag, ovf);
      endfunction

      // Compute the expected result of one word
      function automatic rsp_type alu_predict(input req_type w);
         rsp_type r;
         longint a, b;
         logic [63:0] ma, mb, p, n;
         logic neg, ovf;
         a = longint'(w.operand_a);
         b = longint'(w.operand_b);
         ma = (a < 0) ? 64'(-a) : 64'(a);
         mb = (b < 0) ? 64'(-b) : 64'(b);
         neg = (a < 0) != (b < 0);
         ovf = 1'b0;
         r = '0;
         case (w.op)
            OP_ADD: r.result = saturate_sum(a + b, ovf);
            OP_SUB: r.result = saturate_sum(a - b, ovf);
            OP_MUL: begin
               p = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
               r.result = saturate(neg, p, ovf);
            end
            OP_DIV: begin
               if (mb == 0) r.divide_by_zero = 1'b1;
               else begin
                  n = ma << FRAC_BITS;
                  r.result = saturate(neg, (2 * n + mb) / (2 * mb), ovf);
               end
            end
            OP_MIN: r.result = (a < b) ? w.operand_a : w.operand_b;
            OP_MAX: r.result = (a > b) ? w.operand_a : w.operand_b;
            OP_TOI: r.result = w.operand_a >>> FRAC_BITS;
            OP_FROMI: r.result = saturate(a < 0, ma << FRAC_BITS, ovf);
            OP_INCR: r.result = saturate_sum(a + 1, ovf);
            OP_DECR: r.result = saturate_sum(a - 1, ovf);
            default: r.result = '0;
         endcase
         r.a_greater = a > b;
         r.a_less = a < b;
         r.a_equal = a == b;
         r.overflowed = ovf;
         return r;
      endfunction

      function void note_word(input req_type w);
         pending_rsp.push_back(alu_predict(w));
      endfunction

      task report(input string what);
         $display("mismatch: %s", what);
         err_count++;
      endtask

      task check_word(input rsp_type got);
         rsp_type exp_rsp;
         if (pending_rsp.size() == 0) begin
            report($sformatf("unexpected word %h", got));
            return;
         end
         exp_rsp = pending_rsp.pop_front();
         if (got.result !== exp_rsp.result)
            report($sformatf("result %h, want %h", got.result, exp_rsp.result));
         if (got.a_greater !== exp_rsp.a_greater) report("a_greater");
         if (got.a_less !== exp_rsp.a_less) report("a_less");
         if (got.a_equal !== exp_rsp.a_equal) report("a_equal");
         if (got.overflowed !== exp_rsp.overflowed) report("overflowed");
         if (got.divide_by_zero !== exp_rsp.divide_by_zero) report("divide_by_zero");
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_word;
   alu_scoreboard sb = new();
   bit stall_on = 1'b1;

   fixed_point_q24_8_alu DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Note accepted words and check results at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_word(req_word);
      if (!reset && rsp_valid && rsp_ready) sb.check_word(rsp_word);
   end

   // Stall the receiver on its own pattern
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(negedge clock);
         phase++;
         if (!stall_on) rsp_ready <= 1'b1;
         else if ((phase / 200) % 3 == 2) rsp_ready <= 1'b1;
         else if ((phase / 50) % 2 == 1) rsp_ready <= (phase % 7) != 0;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Drive one word and hold it until accepted
   task send_word(input req_type w);
      req_word <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] edge_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'h0000_0100;
         4: return 32'hFFFF_FF00;
         5: return 32'h0000_0001;
         6: return 32'hFFFF_FFFF;
         7: return $urandom_range(0, 65535) - 32768;
         8: return 32'h0080_0000 ^ ($urandom() & 32'h00FF_FFFF);
         default: return $urandom();
      endcase
   endfunction

   function automatic req_type random_word();
      req_type w;
      w.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
      w.operand_a = ($urandom_range(0, 2) == 0) ? edge_value() : $urandom();
      case ($urandom_range(0, 5))
         0: w.operand_b = w.operand_a;
         1: w.operand_b = edge_value();
         2: w.operand_b = $urandom_range(0, 4095) - 2048;
         default: w.operand_b = $urandom();
      endcase
      return w;
   endfunction

   // Stimulus: directed corners, then bursts of random words
   initial begin
      req_type w;
      logic [31:0] corner_a[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0180, 32'hFFFF_FE80};
      int sent, gap;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int op = 0; op < 10; op++) begin
         send_word('{op: 4'(op), operand_a: corner_a[op % 4], operand_b: corner_a[(op + 1) % 4]});
      end
      send_word('{op: OP_DIV, operand_a: 32'h0000_0500, operand_b: 32'h0});
      send_word('{op: OP_DIV, operand_a: 32'h8000_0000, operand_b: 32'h0000_0001});
      send_word('{op: OP_MUL, operand_a: 32'h0000_0180, operand_b: 32'hFFFF_FF80});
      send_word('{op: OP_MUL, operand_a: 32'h7FFF_FFFF, operand_b: 32'h7FFF_FFFF});
      send_word('{op: OP_INCR, operand_a: 32'h7FFF_FFFF, operand_b: 32'h7FFF_FFFF});
      send_word('{op: OP_DECR, operand_a: 32'h8000_0000, operand_b: 32'h0});
      send_word('{op: OP_FROMI, operand_a: 32'hFF80_0000, operand_b: 32'h1});
      send_word('{op: OP_TOI, operand_a: 32'hFFFF_FFFF, operand_b: 32'h0});
      send_word('{op: 4'd15, operand_a: 32'h5, operand_b: 32'h5});
      send_word('{op: OP_MIN, operand_a: 32'h5, operand_b: 32'h5});
      req_valid <= 1'b0;
      // Hold off until every expected word is back
      while (sb.pending_rsp.size() != 0) @(negedge clock);
      sent = 0;
      while (sent < 1150) begin
         if (sent > 900) stall_on = 1'b0;
         for (int k = $urandom_range(1, 40); k > 0; k--) begin
            w = random_word();
            send_word(w);
            sent++;
         end
         req_valid <= 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (sb.err_count == 0) $display("PASS fixed_point_q24_8_alu");
      else $display("FAIL fixed_point_q24_8_alu");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL fixed_point_q24_8_alu");
      $finish;
   end
endmodule

>>> fixed_point_q24_8_alu.f
sv/fpalu_pkg.sv
sv/fpalu_front.sv
sv/fpalu_div.sv
sv/fixed_point_q24_8_alu.sv
dv/tb_top.sv
